// ===== sv/byte_key_hash_64_top_assert.svh =====
// Assertion macros used by the hash block's queue.
`ifndef BYTE_KEY_HASH_64_TOP_ASSERT_SVH
`define BYTE_KEY_HASH_64_TOP_ASSERT_SVH

// Same-cycle implication.
`define BKH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BKH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bkh_pkg.sv =====
package bkh_pkg;

  localparam logic [31:0] MixMult = 32'h045d9f3b;
  localparam logic [7:0]  LowPad  = 8'd123;
  localparam logic [7:0]  HighPad = 8'd97;
  localparam logic [3:0]  MaxBytes = 4'd8;
  localparam logic [3:0]  HalfBytes = 4'd4;

  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef struct packed {
    logic        mix_en;
    logic        last;
    logic [31:0] hi;
    logic [31:0] lo;
  } bkh_job_t;

  typedef struct packed {
    logic        valid;
    logic        mix_en;
    logic        last;
    logic [31:0] hi;
    logic [31:0] lo;
  } bkh_stage_t;

  function automatic logic [31:0] bkh_xs(input logic [31:0] v);
    return v ^ (v >> 16);
  endfunction

endpackage

// ===== sv/bkh_if.sv =====
interface bkh_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] chunk;
  logic [3:0]  valid_bytes;
  logic        last;

  modport source (output valid, output chunk, output valid_bytes, output last, input ready);
  modport sink (input valid, input chunk, input valid_bytes, input last, output ready);
endinterface

interface bkh_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_code;

  modport source (output valid, output hash_code, input ready);
  modport sink (input valid, input hash_code, output ready);
endinterface

// ===== sv/bkh_front.sv =====
module bkh_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  bkh_in_if.sink            in_i,
  input  logic              full_i,
  output logic              push_o,
  output bkh_pkg::bkh_job_t job_o
);
  import bkh_pkg::*;

  logic       seen_q, seen_d;
  logic [3:0] count;
  logic [31:0] lo_word, hi_word;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    count = (in_i.valid_bytes > MaxBytes) ? MaxBytes : in_i.valid_bytes;
    for (int j = 0; j < 4; j++) begin
      lo_word[8*j +: 8] = (4'(j) < count) ? in_i.chunk[8*j +: 8] : LowPad;
      hi_word[8*j +: 8] = (4'(j + 4) < count) ? in_i.chunk[32 + 8*j +: 8] : HighPad;
    end
  end

  always_comb begin
    job_o.mix_en = (count != 4'd0);
    job_o.last   = in_i.last;
    job_o.lo     = lo_word;
    job_o.hi     = (!seen_q && in_i.last && count <= HalfBytes) ? lo_word : hi_word;
  end

  always_comb begin
    seen_d = seen_q;
    if (push_o) begin
      seen_d = !in_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else begin
      seen_q <= seen_d;
    end
  end

endmodule

// ===== sv/bkh_fifo.sv =====
`include "byte_key_hash_64_top_assert.svh"

module bkh_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bkh_pkg::bkh_job_t job_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              avail_o,
  output bkh_pkg::bkh_job_t job_o
);
  import bkh_pkg::*;

  bkh_job_t mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == FifoCntW'(FifoDepth));
  assign avail_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  `BKH_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= FifoCntW'(FifoDepth), "queue count overflow")
  `BKH_ASSERT_NOW(a_pop_nonempty, pop_i, cnt_q != '0, "pop from empty queue")
  `BKH_ASSERT_NEXT(a_cnt_inc, push_i && !pop_i, cnt_q == $past(cnt_q) + 1'b1,
                   "count missed a push")

endmodule

// ===== sv/bkh_back.sv =====
module bkh_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              avail_i,
  input  bkh_pkg::bkh_job_t job_i,
  output logic              pop_o,
  bkh_out_if.source         out_o
);
  import bkh_pkg::*;

  bkh_stage_t s1_q, s1_d, s2_q, s2_d;
  logic [63:0] code_q, code_d, hash_q, hash_d;
  logic        out_vld_q, out_vld_d;
  logic        adv;
  logic [63:0] mixed;

  assign adv       = !out_vld_q || out_o.ready;
  assign pop_o     = adv && avail_i;
  assign out_o.valid     = out_vld_q;
  assign out_o.hash_code = hash_q;

  always_comb begin
    s1_d.valid  = avail_i;
    s1_d.mix_en = job_i.mix_en;
    s1_d.last   = job_i.last;
    s1_d.hi     = bkh_xs(job_i.hi) * MixMult;
    s1_d.lo     = bkh_xs(job_i.lo) * MixMult;
    s2_d.valid  = s1_q.valid;
    s2_d.mix_en = s1_q.mix_en;
    s2_d.last   = s1_q.last;
    s2_d.hi     = bkh_xs(s1_q.hi) * MixMult;
    s2_d.lo     = bkh_xs(s1_q.lo) * MixMult;
  end

  always_comb begin
    mixed     = s2_q.mix_en ? {bkh_xs(s2_q.hi), bkh_xs(s2_q.lo)} : 64'd0;
    code_d    = code_q;
    hash_d    = hash_q;
    out_vld_d = out_vld_q && !out_o.ready;
    if (adv && s2_q.valid) begin
      code_d = code_q ^ mixed;
      if (s2_q.last) begin
        hash_d    = code_q ^ mixed;
        code_d    = 64'd0;
        out_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q      <= '0;
      s2_q      <= '0;
      out_vld_q <= 1'b0;
      code_q    <= 64'd0;
      hash_q    <= 64'd0;
    end else begin
      if (adv) begin
        s1_q <= s1_d;
        s2_q <= s2_d;
      end
      out_vld_q <= out_vld_d;
      code_q    <= code_d;
      hash_q    <= hash_d;
    end
  end

endmodule

// ===== sv/byte_key_hash_64_top.sv =====
// 64-bit hash of a byte key delivered as 8-byte little-endian chunks.
// Input channel in_i: chunk, valid_bytes (0..8, values above 8 act as 8)
// and last. Each chunk is one request; a key ends with last set.
// Output channel out_o: one hash_code request per key, on its last chunk.
// Throughput: one chunk per cycle. The input side accepts while the
// two-entry queue between front and back has room.
// The hash of a key passes from the queue through the two mixer multiply
// stages; the fold of its last chunk into the output register follows the
// second stage.
// When the receiver stalls, the result stays in the output register, the
// mixer pipeline holds, and the queue fills; in_i.ready drops once it is
// full. Chunks without last still fold through while no result waits.
// Reset clears the queue, the pipeline valids, the running code and the
// start-of-key flag; the block is ready to accept as soon as reset is
// released.
module byte_key_hash_64_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  bkh_in_if.sink    in_i,
  bkh_out_if.source out_o
);
  import bkh_pkg::*;

  logic     push, full, pop, avail;
  bkh_job_t job_in, job_out;

  bkh_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .job_o  (job_in)
  );

  bkh_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .avail_o (avail),
    .job_o   (job_out)
  );

  bkh_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (avail),
    .job_i   (job_out),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ===== bench/bkh_hash_checker.sv =====
module bkh_hash_checker
  import bkh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [63:0] chunk_i,
  input  logic [3:0]  valid_bytes_i,
  input  logic        last_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [63:0] hash_code_i,
  output int          fail_cnt_o,
  output int          pending_o
);

  logic [63:0] fold_code;
  logic        key_open;
  logic [63:0] hash_q[$];

  function automatic logic [31:0] hash_mix(input logic [31:0] v);
    logic [31:0] t;
    t = (v ^ (v >> 16)) * MixMult;
    t = (t ^ (t >> 16)) * MixMult;
    return t ^ (t >> 16);
  endfunction

  // bytes base..base+3, padded past the valid count
  function automatic logic [31:0] gather_word(input logic [63:0] c, input int unsigned cnt,
                                              input int unsigned base, input logic [7:0] pad);
    logic [31:0] w;
    for (int j = 0; j < 4; j++) begin
      w[8*j +: 8] = (base + j < cnt) ? c[8*(base+j) +: 8] : pad;
    end
    return w;
  endfunction

  initial begin
    fail_cnt_o = 0;
    pending_o  = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned cnt;
    logic [31:0] lo_w;
    logic [31:0] hi_w;
    logic [63:0] want;
    if (!rst_ni) begin
      fold_code = '0;
      key_open  = 1'b0;
      hash_q.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (hash_q.size() == 0) begin
          $display("%0t hash_code expected none actual %h", $time, hash_code_i);
          fail_cnt_o++;
        end else begin
          want = hash_q.pop_front();
          if (want !== hash_code_i) begin
            $display("%0t hash_code expected %h actual %h", $time, want, hash_code_i);
            fail_cnt_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        cnt = (valid_bytes_i > MaxBytes) ? MaxBytes : valid_bytes_i;
        if (cnt != 0) begin
          lo_w = gather_word(chunk_i, cnt, 0, LowPad);
          // short key: low word doubles as high word
          if (!key_open && last_i && cnt <= HalfBytes) hi_w = lo_w;
          else hi_w = gather_word(chunk_i, cnt, HalfBytes, HighPad);
          fold_code ^= {hash_mix(hi_w), hash_mix(lo_w)};
        end
        key_open = 1'b1;
        if (last_i) begin
          hash_q.push_back(fold_code);
          fold_code = '0;
          key_open  = 1'b0;
        end
      end
      pending_o = hash_q.size();
    end
  end

endmodule

// ===== bench/tb.sv =====
module tb;
  import bkh_pkg::*;

  localparam int RandItems = 1250;
  localparam int CalmItems = 150;
  localparam int HoldCycles = 300;
  localparam int CycleLimit = 400000;

  logic clk;
  logic rst_n;
  int   fail_cnt;
  int   pending;
  int   sent;
  int   cycles;
  bit   gappy;
  bit   calm;
  bit   stall_req;

  bkh_in_if  in_if ();
  bkh_out_if out_if ();

  byte_key_hash_64_top u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  bkh_hash_checker u_chk (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_if.valid),
    .in_ready_i    (in_if.ready),
    .chunk_i       (in_if.chunk),
    .valid_bytes_i (in_if.valid_bytes),
    .last_i        (in_if.last),
    .out_valid_i   (out_if.valid),
    .out_ready_i   (out_if.ready),
    .hash_code_i   (out_if.hash_code),
    .fail_cnt_o    (fail_cnt),
    .pending_o     (pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  task automatic send_req(input logic [63:0] c, input logic [3:0] vb, input logic lst);
    in_if.valid       <= 1'b1;
    in_if.chunk       <= c;
    in_if.valid_bytes <= vb;
    in_if.last        <= lst;
    do @(posedge clk); while (!in_if.ready);
    sent++;
    if (gappy && !calm && $urandom_range(0, 2) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  function automatic logic [63:0] rand_chunk();
    logic [63:0] c;
    c = {$urandom, $urandom};
    case ($urandom_range(0, 15))
      0: c = '0;
      1: c = '1;
      default: ;
    endcase
    return c;
  endfunction

  task automatic send_key();
    int          nchunks;
    bit          noisy;
    logic [3:0]  vb;
    nchunks = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 9) : $urandom_range(1, 4);
    noisy   = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < nchunks; i++) begin
      vb = (i == nchunks - 1) ? 4'($urandom_range(1, 8)) : MaxBytes;
      if (noisy && $urandom_range(0, 2) == 0) vb = 4'($urandom_range(0, 15));
      send_req(rand_chunk(), vb, i == nchunks - 1);
    end
  endtask

  // result side
  initial begin
    bit held;
    held = 1'b0;
    out_if.ready <= 1'b0;
    wait (rst_n);
    forever begin
      if (stall_req && !held) begin
        held = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("byte_key_hash_64_top: mismatch");
    $finish;
  end

  initial begin
    int directed;
    sent      = 0;
    gappy     = 1'b1;
    calm      = 1'b0;
    stall_req = 1'b0;
    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.chunk       <= '0;
    in_if.valid_bytes <= '0;
    in_if.last        <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty key, garbage bytes ignored
    send_req('1, 4'd0, 1'b1);
    // single-chunk keys of every length
    send_req('1, 4'd1, 1'b1);
    send_req(rand_chunk(), 4'd2, 1'b1);
    send_req('0, 4'd3, 1'b1);
    send_req('1, HalfBytes, 1'b1);
    send_req(64'h0123_4567_89ab_cdef, 4'd5, 1'b1);
    send_req(rand_chunk(), 4'd6, 1'b1);
    send_req(rand_chunk(), 4'd7, 1'b1);
    send_req('1, MaxBytes, 1'b1);
    // counts above eight saturate
    send_req(rand_chunk(), 4'd9, 1'b1);
    send_req('1, 4'd15, 1'b1);
    // short tail on a multi-chunk key: no low-word reuse
    send_req('1, MaxBytes, 1'b0);
    send_req(rand_chunk(), 4'd3, 1'b1);
    // short chunk that is not last
    send_req(rand_chunk(), 4'd2, 1'b0);
    send_req(rand_chunk(), MaxBytes, 1'b1);
    // empty first chunk still marks the key as started
    send_req(rand_chunk(), 4'd0, 1'b0);
    send_req(rand_chunk(), 4'd2, 1'b1);
    send_req('0, MaxBytes, 1'b0);
    send_req('1, 4'd0, 1'b1);
    send_req(64'hffff_ffff_0000_0000, HalfBytes, 1'b1);
    send_req(rand_chunk(), 4'd12, 1'b0);
    send_req(rand_chunk(), 4'd7, 1'b1);
    directed = sent;

    // long receiver hold while keys keep coming
    stall_req = 1'b1;
    repeat (60) send_req(rand_chunk(), 4'($urandom_range(1, 8)), 1'b1);

    while (sent < directed + RandItems) begin
      if ($urandom_range(0, 29) == 0) gappy = !gappy;
      if (sent >= directed + RandItems - CalmItems) calm = 1'b1;
      send_key();
    end
    in_if.valid <= 1'b0;

    @(posedge clk);
    wait (pending == 0);
    repeat (10) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("byte_key_hash_64_top: match");
    end else begin
      $display("byte_key_hash_64_top: mismatch");
    end
    $finish;
  end

endmodule
